### sv/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/lrps_pkg.sv
`default_nettype none
package lrps_pkg;

	localparam int CMD_W   = 2;
	localparam int ST_W    = 6;
	localparam int SYM_W   = 7;
	localparam int LEN_W   = 4;
	localparam int KIND_W  = 3;
	localparam int TENT_W  = ST_W + 1;
	localparam int RENT_W  = 1 + SYM_W + LEN_W;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_TRANS  = 2'd0,
		CMD_WR_REDUCE = 2'd1,
		CMD_FEED      = 2'd2,
		CMD_RESTART   = 2'd3
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SHIFT  = 3'd0,
		KIND_REDUCE = 3'd1,
		KIND_ACCEPT = 3'd2,
		KIND_REJECT = 3'd3,
		KIND_ERROR  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_RD,
		ST_RED_CHK,
		ST_TOP,
		ST_GOTO,
		ST_SH_CHK,
		ST_EMIT
	} fsm_t;

	// reduce entry as stored
	typedef struct packed {
		logic             flag;
		logic [SYM_W-1:0] lhs;
		logic [LEN_W-1:0] len;
	} rent_t;

endpackage
`default_nettype wire

### sv/lrps_tables.sv
`default_nettype none
module lrps_tables #(
	parameter int NUM_STATES  = 64,
	parameter int NUM_SYMBOLS = 128
) (
	input  wire logic                                              clk,
	input  wire logic                                              arst_n,
	output logic                                                   busy,
	input  wire logic                                              t_we,
	input  wire logic [$clog2(NUM_STATES*NUM_SYMBOLS)-1:0]         t_waddr,
	input  wire logic [lrps_pkg::TENT_W-1:0]                       t_wdata,
	input  wire logic [$clog2(NUM_STATES*NUM_SYMBOLS)-1:0]         t_raddr,
	output logic      [lrps_pkg::TENT_W-1:0]                       t_rdata,
	input  wire logic                                              r_we,
	input  wire logic [$clog2(NUM_STATES)-1:0]                     r_waddr,
	input  wire lrps_pkg::rent_t                                   r_wdata,
	input  wire logic [$clog2(NUM_STATES)-1:0]                     r_raddr,
	output lrps_pkg::rent_t                                        r_rdata
);
	import lrps_pkg::*;

	localparam int TDEPTH = NUM_STATES * NUM_SYMBOLS;
	localparam int TAW    = $clog2(TDEPTH);

	logic [TENT_W-1:0] tmem [TDEPTH];
	rent_t             rmem [NUM_STATES];
	logic [NUM_STATES-1:0] rvalid_q;
	logic              clr_busy_q;
	logic [TAW-1:0]    clr_q;
	rent_t             rraw_q;
	logic              rhit_q;

	assign busy = clr_busy_q;

	// clearing sweep over the transition memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + TAW'(1);
			if (32'(clr_q) == TDEPTH - 1) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) tmem[clr_q] <= '0;
		else if (t_we) tmem[t_waddr] <= t_wdata;
		t_rdata <= tmem[t_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rvalid_q <= '0;
		else if (r_we) rvalid_q[r_waddr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (r_we) rmem[r_waddr] <= r_wdata;
		rraw_q <= rmem[r_raddr];
		rhit_q <= rvalid_q[r_raddr];
	end

	// never-written entries read as non-reducing
	assign r_rdata = rhit_q ? rraw_q : '0;

endmodule
`default_nettype wire

### sv/lrps_stack.sv
`default_nettype none
module lrps_stack #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(STACK_DEPTH)-1:0]   waddr,
	input  wire logic [lrps_pkg::ST_W-1:0]        wdata,
	input  wire logic [$clog2(STACK_DEPTH)-1:0]   raddr,
	output logic      [lrps_pkg::ST_W-1:0]        rdata
);
	import lrps_pkg::*;

	logic [ST_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### sv/lr0_table_driven_parse_step_core.sv
`default_nettype none
// LR(0) shift-reduce parse engine. Every input transfer carries a command in s_tuser:
// write a transition (shift or goto) entry, write a state's reduce entry, feed a
// terminal, or restart the parse (stack holds state 0 only). Load and restart give no
// result. A fed terminal first runs every reduction the current state calls for, each
// giving a reduce result with tlast low, then ends with one result with tlast high:
// shift, accept (terminal 0), reject, or error (missing goto, stack over or underflow,
// too many reductions, or the parse already stopped). The transition table, reduce
// table and parse stack sit in synchronous memories with registered reads; each
// reduction runs a chain of dependent steps (reduce-table read, stack read of the
// exposed state, goto read, result transfer). After reset the transition memory is
// cleared one entry a cycle while s_tready stays low. A finished result waits in the
// output register without stalling the input.
module lr0_table_driven_parse_step_core #(
	parameter int NUM_STATES     = 64,
	parameter int NUM_SYMBOLS    = 128,
	parameter int STACK_DEPTH    = 64,
	parameter int MAX_REDUCTIONS = 63
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// state_index, symbol, dest_state, entry_valid, reduce_flag, lhs_symbol, rhs_length
	input  wire logic [lrps_pkg::S_DATA_W-1:0]   s_tdata,
	// cmd
	input  wire logic [lrps_pkg::CMD_W-1:0]      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// state_after, reduced_symbol, reduced_length, zero fill
	output logic      [lrps_pkg::M_DATA_W-1:0]   m_tdata,
	// kind
	output logic      [lrps_pkg::KIND_W-1:0]     m_tuser,
	output logic                                 m_tlast
);
	import lrps_pkg::*;

	localparam int TAW = $clog2(NUM_STATES * NUM_SYMBOLS);
	localparam int RAW = $clog2(NUM_STATES);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int RW  = $clog2(MAX_REDUCTIONS + 1);

	// input field unpacking
	logic [ST_W-1:0]  in_sidx, in_dst;
	logic [SYM_W-1:0] in_sym, in_lhs;
	logic [LEN_W-1:0] in_rlen;
	logic             in_valid, in_rflag;
	cmd_t             in_cmd;

	assign in_sidx  = s_tdata[5:0];
	assign in_sym   = s_tdata[12:6];
	assign in_dst   = s_tdata[18:13];
	assign in_valid = s_tdata[19];
	assign in_rflag = s_tdata[20];
	assign in_lhs   = s_tdata[27:21];
	assign in_rlen  = s_tdata[31:28];
	assign in_cmd   = cmd_t'(s_tuser);

	// parse state
	fsm_t             state_q, state_nxt;
	logic [ST_W-1:0]  cur_q;
	logic [CW-1:0]    cnt_q;
	logic             running_q;
	logic [RW-1:0]    red_q;
	logic [SYM_W-1:0] sym_q;
	logic [SYM_W-1:0] rsym_q;
	logic [LEN_W-1:0] rlen_q;
	logic [CW-1:0]    remain_q;
	logic             key_ok_q;

	// pending result and output register
	kind_t            res_kind_q;
	logic [ST_W-1:0]  res_st_q;
	logic [SYM_W-1:0] res_sym_q;
	logic [LEN_W-1:0] res_len_q;
	logic             res_last_q;
	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [ST_W-1:0]  out_st_q;
	logic [SYM_W-1:0] out_sym_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_last_q;

	// memory ports
	logic             tbl_busy;
	logic             t_we;
	logic [TAW-1:0]   t_waddr, t_raddr;
	logic [TENT_W-1:0] t_wdata, t_rdata;
	logic             r_we;
	rent_t            r_wdata, r_rdata;
	logic             stk_we;
	logic [SAW-1:0]   stk_waddr, stk_raddr;
	logic [ST_W-1:0]  stk_wdata, stk_rdata;

	logic             in_xfer, out_free;
	logic             load_ok;
	logic [ST_W-1:0]  top_st;
	logic             red_err, goto_err;

	lrps_tables #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_tables (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (tbl_busy),
		.t_we    (t_we),
		.t_waddr (t_waddr),
		.t_wdata (t_wdata),
		.t_raddr (t_raddr),
		.t_rdata (t_rdata),
		.r_we    (r_we),
		.r_waddr (RAW'(in_sidx)),
		.r_wdata (r_wdata),
		.r_raddr (RAW'(cur_q)),
		.r_rdata (r_rdata)
	);

	lrps_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign s_tready = (state_q == ST_IDLE) && !tbl_busy;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign top_st   = stk_rdata;

	assign load_ok = (32'(in_sidx) < NUM_STATES) && (32'(in_sym) < NUM_SYMBOLS)
		&& (32'(in_dst) < NUM_STATES);

	assign t_waddr = TAW'(32'(in_sidx) * NUM_SYMBOLS + 32'(in_sym));
	assign t_wdata = in_valid ? {1'b1, in_dst} : '0;
	assign t_we    = in_xfer && (in_cmd == CMD_WR_TRANS) && load_ok;
	assign r_wdata = '{flag: in_rflag, lhs: in_lhs, len: in_rlen};
	assign r_we    = in_xfer && (in_cmd == CMD_WR_REDUCE) && (32'(in_sidx) < NUM_STATES);

	// reduction bound and underflow checks on the fresh reduce entry
	assign red_err  = (32'(red_q) >= MAX_REDUCTIONS) || (32'(r_rdata.len) >= 32'(cnt_q));
	// goto missing or no room for the pushed state
	assign goto_err = !key_ok_q || !t_rdata[ST_W] || (32'(remain_q) >= STACK_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	// next state and memory controls
	always_comb begin
		state_nxt = state_q;
		t_raddr   = TAW'(32'(cur_q) * NUM_SYMBOLS + 32'(sym_q));
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_raddr = SAW'(remain_q - CW'(1));
		unique case (state_q)
			ST_IDLE: begin
				// stack bottom holds state 0 from reset and from restart
				if (tbl_busy || (in_xfer && in_cmd == CMD_RESTART)) stk_we = 1'b1;
				if (in_xfer && in_cmd == CMD_FEED)
					state_nxt = running_q ? ST_RED_CHK : ST_EMIT;
			end
			ST_RED_RD: state_nxt = ST_RED_CHK;
			ST_RED_CHK: begin
				stk_raddr = SAW'(cnt_q - CW'(r_rdata.len) - CW'(1));
				if (!r_rdata.flag) state_nxt = ST_SH_CHK;
				else if (red_err) state_nxt = ST_EMIT;
				else state_nxt = ST_TOP;
			end
			ST_TOP: begin
				t_raddr   = TAW'(32'(top_st) * NUM_SYMBOLS + 32'(rsym_q));
				state_nxt = ST_GOTO;
			end
			ST_GOTO: begin
				if (!goto_err) begin
					stk_we    = 1'b1;
					stk_waddr = SAW'(remain_q);
					stk_wdata = t_rdata[ST_W-1:0];
				end
				state_nxt = ST_EMIT;
			end
			ST_SH_CHK: begin
				if (key_ok_q && t_rdata[ST_W] && sym_q != '0
						&& 32'(cnt_q) < STACK_DEPTH) begin
					stk_we    = 1'b1;
					stk_waddr = SAW'(cnt_q);
					stk_wdata = t_rdata[ST_W-1:0];
				end
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_nxt = res_last_q ? ST_IDLE : ST_RED_RD;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// parse registers and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			cnt_q     <= CW'(1);
			running_q <= 1'b1;
			red_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_cmd == CMD_RESTART) begin
						cur_q     <= '0;
						cnt_q     <= CW'(1);
						running_q <= 1'b1;
					end
					if (in_xfer && in_cmd == CMD_FEED) red_q <= '0;
				end
				ST_RED_CHK: begin
					if (r_rdata.flag && red_err) running_q <= 1'b0;
				end
				ST_GOTO: begin
					if (goto_err) running_q <= 1'b0;
					else begin
						cur_q <= t_rdata[ST_W-1:0];
						cnt_q <= remain_q + CW'(1);
						red_q <= red_q + RW'(1);
					end
				end
				ST_SH_CHK: begin
					if (!key_ok_q || !t_rdata[ST_W] || sym_q == '0
							|| 32'(cnt_q) >= STACK_DEPTH)
						running_q <= 1'b0;
					else begin
						cur_q <= t_rdata[ST_W-1:0];
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sym_q      <= in_sym;
				// a stopped parse answers with an error and the unchanged state
				res_kind_q <= KIND_ERROR;
				res_st_q   <= cur_q;
				res_sym_q  <= '0;
				res_len_q  <= '0;
				res_last_q <= 1'b1;
			end
			ST_RED_CHK: begin
				rsym_q   <= r_rdata.lhs;
				rlen_q   <= r_rdata.len;
				remain_q <= cnt_q - CW'(r_rdata.len);
				key_ok_q <= r_rdata.flag
					? (32'(r_rdata.lhs) < NUM_SYMBOLS)
					: ((32'(sym_q) < NUM_SYMBOLS) && (32'(cur_q) < NUM_STATES));
				res_kind_q <= KIND_ERROR;
				res_st_q   <= cur_q;
				res_sym_q  <= '0;
				res_len_q  <= '0;
				res_last_q <= 1'b1;
			end
			ST_TOP: key_ok_q <= key_ok_q && (32'(top_st) < NUM_STATES);
			ST_GOTO: begin
				if (!goto_err) begin
					res_kind_q <= KIND_REDUCE;
					res_st_q   <= t_rdata[ST_W-1:0];
					res_sym_q  <= rsym_q;
					res_len_q  <= rlen_q;
					res_last_q <= 1'b0;
				end
			end
			ST_SH_CHK: begin
				if (!key_ok_q || !t_rdata[ST_W]) res_kind_q <= KIND_REJECT;
				else if (sym_q == '0) res_kind_q <= KIND_ACCEPT;
				else if (32'(cnt_q) >= STACK_DEPTH) res_kind_q <= KIND_ERROR;
				else begin
					res_kind_q <= KIND_SHIFT;
					res_st_q   <= t_rdata[ST_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// output register, loaded from the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_kind_q <= res_kind_q;
			out_st_q   <= res_st_q;
			out_sym_q  <= res_sym_q;
			out_len_q  <= res_len_q;
			out_last_q <= res_last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_len_q, out_sym_q, out_st_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

### sv/lrps_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lrps_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [lrps_pkg::M_DATA_W-1:0]   m_tdata,
	input wire logic [lrps_pkg::KIND_W-1:0]     m_tuser,
	input wire logic                            m_tlast
);
	import lrps_pkg::*;

	// only reduce results leave the item open
	`ASSERT_SAME(a_reduce_not_last, clk, arst_n, m_tvalid && m_tuser == KIND_REDUCE, !m_tlast)
	`ASSERT_SAME(a_other_last, clk, arst_n, m_tvalid && m_tuser != KIND_REDUCE, m_tlast)
	// non-reduce results carry no symbol or length
	`ASSERT_SAME(a_other_zero, clk, arst_n, m_tvalid && m_tuser != KIND_REDUCE,
		m_tdata[16:6] == '0)
	// an open item keeps the input closed
	`ASSERT_SAME(a_open_busy, clk, arst_n, m_tvalid && !m_tlast, !s_tready)
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind lr0_table_driven_parse_step_core lrps_checker u_lrps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
